/* rtl/peer_address_client_table_macros.svh */
// Assertion macros for the peer address client table
`ifndef PEER_ADDRESS_CLIENT_TABLE_MACROS_SVH
`define PEER_ADDRESS_CLIENT_TABLE_MACROS_SVH
// Checked on every clock edge, masked during reset
`define PACT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included
`define PACT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/pact_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pact_pkg
// Types and constants of the peer address client table.
// ----------------------------------------------------------------------------
package pact_pkg;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam int          CNT_W      = 11;

  // operation codes
  typedef enum logic [1:0] {
    OP_GET_CREATE = 2'd0,
    OP_ADDR_BY_ID = 2'd1,
    OP_PROTO_BY_ID = 2'd2,
    OP_SET_PROTO  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_ID_BASE   = 2'd0;
  localparam logic [1:0] REG_BROADCAST = 2'd1;
  localparam logic [1:0] REG_MAX_CLI   = 2'd2;

  // protocol codes
  localparam logic [1:0] PROTO_UNKNOWN = 2'd0;
  localparam logic [1:0] PROTO_CSV     = 2'd1;
  localparam logic [1:0] PROTO_BINARY  = 2'd2;

  // one table slot as held in the RAM
  typedef struct packed {
    logic        active;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] id;
    logic [31:0] last;
    logic [1:0]  proto;
  } slot_t;

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_MUL1 = 13'b0000000000100,
    S_MUL2 = 13'b0000000001000,
    S_MOD  = 13'b0000000010000,
    S_PRD  = 13'b0000000100000,
    S_PEV  = 13'b0000001000000,
    S_ERD  = 13'b0000010000000,
    S_EEV  = 13'b0000100000000,
    S_EWR  = 13'b0001000000000,
    S_CRT  = 13'b0010000000000,
    S_SRD  = 13'b0100000000000,
    S_SEV  = 13'b1000000000000
  } state_t;

  // one result
  typedef struct packed {
    logic [31:0]      id;
    logic             hit;
    logic             fb;
    logic [31:0]      addr;
    logic [15:0]      port;
    logic [1:0]       proto;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

/* rtl/pact_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pact_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/peer_address_client_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_address_client_table
// Maps peer address and port to client ids in a linearly probed table held
// in one RAM, with least recently seen eviction and lookups by id.
// ----------------------------------------------------------------------------
//  channel | ports                        | handshake
//  request | start, busy, in_*            | taken when start && !busy
//  result  | out_valid, out_*             | one cycle strobe, no back pressure
//  config  | cfg_valid, cfg_ready, cfg_*  | written when valid && ready
//
// Every slot visit is a RAM read, then an evaluate step, on one port.
// Get or create / set protocol: hashing and reduction (S_MUL1, S_MUL2,
// S_MOD), then one visit per probed slot; an eviction scan visits every
// slot, then frees the oldest entry. Lookups by id visit at most
// TABLE_SIZE slots. One request at a time. After reset a clearing pass
// over all slots runs with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "peer_address_client_table_macros.svh"

module peer_address_client_table #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_peer_addr,
  input  logic [15:0] in_peer_port,
  input  logic [31:0] in_query_id,
  input  logic [1:0]  in_new_protocol,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  output logic [31:0] out_result_id,
  output logic        out_hit,
  output logic        out_fallback,
  output logic [31:0] out_found_addr,
  output logic [15:0] out_found_port,
  output logic [1:0]  out_protocol_out,
  output logic [10:0] out_client_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam int NW   = IDXW + 1;
  localparam int CW   = $clog2(TABLE_SIZE + 1);
  localparam int CMPW = (CW > pact_pkg::CNT_W) ? CW : pact_pkg::CNT_W;
  localparam int SW   = $bits(pact_pkg::slot_t);
  localparam logic [NW-1:0]   LASTN   = NW'(TABLE_SIZE - 1);
  localparam logic [IDXW-1:0] LASTIDX = IDXW'(TABLE_SIZE - 1);
  localparam logic [31:0]     TSZ32   = 32'(TABLE_SIZE);
  // floor(2^32 / TABLE_SIZE): quotient estimate is low by at most one
  localparam logic [31:0]     RECIP   = 32'((64'd1 << 32) / 64'(TABLE_SIZE));

  typedef struct packed {
    pact_pkg::state_t state;
    logic [1:0]       op;
    logic [31:0]      addr;
    logic [15:0]      port;
    logic [31:0]      qid;
    logic [1:0]       proto;
    logic [31:0]      now;
    logic [31:0]      hash;
    logic [31:0]      quo;
    logic [1:0]       ph;
    logic [IDXW-1:0]  idx;
    logic [IDXW-1:0]  home;
    logic [NW-1:0]    n;
    logic             second;
    logic [IDXW-1:0]  slot;
    logic [IDXW-1:0]  best;
    logic [31:0]      best_t;
    logic             found;
    logic             evc;
    logic [CW-1:0]    count;
    logic [31:0]      nid;
  } ctx_t;

  ctx_t              ctx_r, ctx_nxt;
  pact_pkg::res_t    res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       base_r, bcast_r;
  logic [10:0]       maxc_r;

  logic              ram_we;
  logic [IDXW-1:0]   ram_waddr;
  pact_pkg::slot_t   ram_wslot;
  logic [SW-1:0]     ram_rdata;
  pact_pkg::slot_t   ent;

  logic [63:0]       hash_prod;
  logic [31:0]       quo_t, red_v;
  logic [IDXW-1:0]   idx_inc;
  logic [31:0]       nid_inc, nid_wrap;
  logic              last_n, key_eq, cnt_full;
  logic [CMPW-1:0]   cnt_ext, max_ext;

  // slot store
  pact_ram #(.WIDTH(SW), .DEPTH(TABLE_SIZE)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .raddr (ctx_r.idx),
    .rdata (ram_rdata)
  );

  assign ent = pact_pkg::slot_t'(ram_rdata);

  // shared helpers
  assign hash_prod = {32'd0, ctx_r.hash} * {32'd0, RECIP};
  assign quo_t     = ctx_r.quo * TSZ32;
  assign red_v     = (ctx_r.hash >= TSZ32) ? ctx_r.hash - TSZ32 : ctx_r.hash;
  assign idx_inc  = (ctx_r.idx == LASTIDX) ? '0 : ctx_r.idx + 1'b1;
  assign nid_inc  = ctx_r.nid + 32'd1;
  assign nid_wrap = (nid_inc < base_r) ? base_r + 32'd1 : nid_inc;
  assign last_n   = (ctx_r.n == LASTN);
  assign key_eq   = (ent.addr == ctx_r.addr) && (ent.port == ctx_r.port);
  assign cnt_ext  = CMPW'(ctx_r.count);
  assign max_ext  = CMPW'(maxc_r);
  assign cnt_full = (cnt_ext >= max_ext);

  // sequencer
  always_comb begin
    ctx_nxt       = ctx_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ctx_r.idx;
    ram_wslot     = '0;

    if (cfg_valid && (cfg_index == pact_pkg::REG_ID_BASE)) begin
      ctx_nxt.nid = cfg_data + 32'd1;
    end

    unique case (ctx_r.state)
      pact_pkg::S_CLR: begin
        ram_we      = 1'b1;
        ctx_nxt.idx = idx_inc;
        ctx_nxt.n   = ctx_r.n + 1'b1;
        if (last_n) begin
          ctx_nxt.state = pact_pkg::S_IDLE;
        end
      end
      pact_pkg::S_IDLE: begin
        if (start) begin
          ctx_nxt.op    = in_operation;
          ctx_nxt.addr  = in_peer_addr;
          ctx_nxt.port  = in_peer_port;
          ctx_nxt.qid   = in_query_id;
          ctx_nxt.proto = in_new_protocol;
          ctx_nxt.now   = in_now_seconds;
          ctx_nxt.idx   = '0;
          ctx_nxt.n     = '0;
          if (in_operation == pact_pkg::OP_ADDR_BY_ID ||
              in_operation == pact_pkg::OP_PROTO_BY_ID) begin
            ctx_nxt.state = pact_pkg::S_SRD;
          end else begin
            ctx_nxt.state = pact_pkg::S_MUL1;
          end
        end
      end
      // two FNV-1a rounds, one multiply per cycle
      pact_pkg::S_MUL1: begin
        ctx_nxt.hash  = (pact_pkg::FNV_OFFSET ^ ctx_r.addr) * pact_pkg::FNV_PRIME;
        ctx_nxt.state = pact_pkg::S_MUL2;
      end
      pact_pkg::S_MUL2: begin
        ctx_nxt.hash  = (ctx_r.hash ^ {16'd0, ctx_r.port}) * pact_pkg::FNV_PRIME;
        ctx_nxt.ph    = 2'd0;
        ctx_nxt.state = pact_pkg::S_MOD;
      end
      // hash modulo table size: reciprocal quotient, remainder, one correction
      pact_pkg::S_MOD: begin
        ctx_nxt.ph = ctx_r.ph + 2'd1;
        if (ctx_r.ph == 2'd0) begin
          ctx_nxt.quo = hash_prod[63:32];
        end else if (ctx_r.ph == 2'd1) begin
          ctx_nxt.hash = ctx_r.hash - quo_t;
        end else begin
          ctx_nxt.idx    = red_v[IDXW-1:0];
          ctx_nxt.home   = red_v[IDXW-1:0];
          ctx_nxt.n      = '0;
          ctx_nxt.second = 1'b0;
          ctx_nxt.state  = pact_pkg::S_PRD;
        end
      end
      pact_pkg::S_PRD: begin
        ctx_nxt.state = pact_pkg::S_PEV;
      end
      // linear probe step
      pact_pkg::S_PEV: begin
        if (!ent.active) begin
          ctx_nxt.slot = ctx_r.idx;
          if (ctx_r.op == pact_pkg::OP_SET_PROTO) begin
            res_nxt       = '0;
            res_nxt.count = pact_pkg::CNT_W'(cnt_ext);
            out_valid_nxt = 1'b1;
            ctx_nxt.state = pact_pkg::S_IDLE;
          end else if (cnt_full) begin
            ctx_nxt.evc   = 1'b1;
            ctx_nxt.idx   = '0;
            ctx_nxt.n     = '0;
            ctx_nxt.found = 1'b0;
            ctx_nxt.state = pact_pkg::S_ERD;
          end else begin
            ctx_nxt.state = pact_pkg::S_CRT;
          end
        end else if (key_eq) begin
          ram_we        = 1'b1;
          ram_wslot     = ent;
          res_nxt       = '0;
          res_nxt.id    = ent.id;
          res_nxt.hit   = 1'b1;
          res_nxt.count = pact_pkg::CNT_W'(cnt_ext);
          if (ctx_r.op == pact_pkg::OP_SET_PROTO) begin
            if (ent.proto == pact_pkg::PROTO_UNKNOWN &&
                (ctx_r.proto == pact_pkg::PROTO_CSV ||
                 ctx_r.proto == pact_pkg::PROTO_BINARY)) begin
              ram_wslot.proto = ctx_r.proto;
            end
            res_nxt.proto = ram_wslot.proto;
          end else begin
            ram_wslot.last = ctx_r.now;
          end
          out_valid_nxt = 1'b1;
          ctx_nxt.state = pact_pkg::S_IDLE;
        end else if (last_n) begin
          if (ctx_r.op == pact_pkg::OP_GET_CREATE && !ctx_r.second) begin
            ctx_nxt.evc   = 1'b0;
            ctx_nxt.idx   = '0;
            ctx_nxt.n     = '0;
            ctx_nxt.found = 1'b0;
            ctx_nxt.state = pact_pkg::S_ERD;
          end else begin
            res_nxt       = '0;
            res_nxt.count = pact_pkg::CNT_W'(cnt_ext);
            if (ctx_r.op == pact_pkg::OP_GET_CREATE) begin
              res_nxt.id = bcast_r;
              res_nxt.fb = 1'b1;
            end
            out_valid_nxt = 1'b1;
            ctx_nxt.state = pact_pkg::S_IDLE;
          end
        end else begin
          ctx_nxt.idx   = idx_inc;
          ctx_nxt.n     = ctx_r.n + 1'b1;
          ctx_nxt.state = pact_pkg::S_PRD;
        end
      end
      pact_pkg::S_ERD: begin
        ctx_nxt.state = pact_pkg::S_EEV;
      end
      // oldest entry scan, lowest index wins a tie
      pact_pkg::S_EEV: begin
        if (ent.active && (!ctx_r.found || ent.last < ctx_r.best_t)) begin
          ctx_nxt.best   = ctx_r.idx;
          ctx_nxt.best_t = ent.last;
          ctx_nxt.found  = 1'b1;
        end
        ctx_nxt.idx   = idx_inc;
        ctx_nxt.n     = ctx_r.n + 1'b1;
        ctx_nxt.state = last_n ? pact_pkg::S_EWR : pact_pkg::S_ERD;
      end
      pact_pkg::S_EWR: begin
        if (ctx_r.found) begin
          ram_we        = 1'b1;
          ram_waddr     = ctx_r.best;
          ctx_nxt.count = ctx_r.count - 1'b1;
        end
        if (ctx_r.evc) begin
          ctx_nxt.state = pact_pkg::S_CRT;
        end else begin
          ctx_nxt.second = 1'b1;
          ctx_nxt.idx    = ctx_r.home;
          ctx_nxt.n      = '0;
          ctx_nxt.state  = pact_pkg::S_PRD;
        end
      end
      // new entry
      pact_pkg::S_CRT: begin
        ram_we           = 1'b1;
        ram_waddr        = ctx_r.slot;
        ram_wslot.active = 1'b1;
        ram_wslot.addr   = ctx_r.addr;
        ram_wslot.port   = ctx_r.port;
        ram_wslot.id     = ctx_r.nid;
        ram_wslot.last   = ctx_r.now;
        ram_wslot.proto  = pact_pkg::PROTO_UNKNOWN;
        ctx_nxt.count    = ctx_r.count + 1'b1;
        ctx_nxt.nid      = nid_wrap;
        res_nxt          = '0;
        res_nxt.id       = ctx_r.nid;
        res_nxt.count    = pact_pkg::CNT_W'(CMPW'(ctx_r.count + 1'b1));
        out_valid_nxt    = 1'b1;
        ctx_nxt.state    = pact_pkg::S_IDLE;
      end
      pact_pkg::S_SRD: begin
        ctx_nxt.state = pact_pkg::S_SEV;
      end
      // search by id, lowest slot wins
      pact_pkg::S_SEV: begin
        if ((ent.active && ent.id == ctx_r.qid) || last_n) begin
          res_nxt       = '0;
          res_nxt.count = pact_pkg::CNT_W'(cnt_ext);
          if (ent.active && ent.id == ctx_r.qid) begin
            res_nxt.id  = ctx_r.qid;
            res_nxt.hit = 1'b1;
            if (ctx_r.op == pact_pkg::OP_ADDR_BY_ID) begin
              res_nxt.addr = ent.addr;
              res_nxt.port = ent.port;
            end else begin
              res_nxt.proto = ent.proto;
            end
          end
          out_valid_nxt = 1'b1;
          ctx_nxt.state = pact_pkg::S_IDLE;
        end else begin
          ctx_nxt.idx   = idx_inc;
          ctx_nxt.n     = ctx_r.n + 1'b1;
          ctx_nxt.state = pact_pkg::S_SRD;
        end
      end
      default: begin
        ctx_nxt.state = pact_pkg::S_IDLE;
      end
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state <= pact_pkg::S_CLR;
      ctx_r.idx   <= '0;
      ctx_r.n     <= '0;
      ctx_r.count <= '0;
      ctx_r.nid   <= 32'h8000_0001;
      out_valid_r <= 1'b0;
      base_r      <= 32'h8000_0000;
      bcast_r     <= 32'd0;
      maxc_r      <= 11'd1024;
    end else begin
      ctx_r       <= ctx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pact_pkg::REG_ID_BASE:   base_r  <= cfg_data;
          pact_pkg::REG_BROADCAST: bcast_r <= cfg_data;
          pact_pkg::REG_MAX_CLI:   maxc_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy             = (ctx_r.state != pact_pkg::S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_id    = res_r.id;
  assign out_hit          = res_r.hit;
  assign out_fallback     = res_r.fb;
  assign out_found_addr   = res_r.addr;
  assign out_found_port   = res_r.port;
  assign out_protocol_out = res_r.proto;
  assign out_client_count = res_r.count;

  // checks
  `PACT_ASSERT(a_res_then_idle, out_valid_r |-> ctx_r.state == pact_pkg::S_IDLE, "result not at idle")
  `PACT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request not taken")
  `PACT_ASSERT(a_count_range, CMPW'(ctx_r.count) <= CMPW'(TABLE_SIZE), "count overflow")
  `PACT_ASSERT(a_no_res_clr, (ctx_r.state == pact_pkg::S_CLR) |-> !out_valid_r, "result in clear")
  `PACT_ASSERT_ALWAYS(a_rst_clr, !rst_n |=> ctx_r.state == pact_pkg::S_CLR, "no clear after reset")

endmodule

/* tb/peer_address_client_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_address_client_table_checker
// Watches the request, result and register channels of the client table.
// Keeps its own copy of the table, predicts one result per accepted request
// and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module peer_address_client_table_checker #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_peer_addr,
  input  logic [15:0] in_peer_port,
  input  logic [31:0] in_query_id,
  input  logic [1:0]  in_new_protocol,
  input  logic [31:0] in_now_seconds,
  input  logic        out_valid,
  input  logic [31:0] out_result_id,
  input  logic        out_hit,
  input  logic        out_fallback,
  input  logic [31:0] out_found_addr,
  input  logic [15:0] out_found_port,
  input  logic [1:0]  out_protocol_out,
  input  logic [10:0] out_client_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output int          results_seen,
  output int          hits_seen,
  output int          evictions
);

  typedef enum int { PR_MATCH, PR_EMPTY, PR_FULL } probe_res_t;

  // mirrored registers and table
  logic [31:0] base_id, bcast_id;
  logic [10:0] client_limit;
  logic        t_active [SLOTS];
  logic [31:0] t_addr   [SLOTS];
  logic [15:0] t_port   [SLOTS];
  logic [31:0] t_id     [SLOTS];
  logic [31:0] t_seen   [SLOTS];
  logic [1:0]  t_proto  [SLOTS];
  logic [10:0] n_clients;
  logic [31:0] issue_id;

  pact_pkg::res_t expected_results[$];

  function automatic logic [31:0] fnv_key(logic [31:0] a, logic [15:0] p);
    logic [31:0] h;
    h = (pact_pkg::FNV_OFFSET ^ a) * pact_pkg::FNV_PRIME;
    h = (h ^ {16'd0, p}) * pact_pkg::FNV_PRIME;
    return h;
  endfunction

  // linear probe: stops at a matching key or the first empty slot
  function automatic probe_res_t probe_slot(logic [31:0] a, logic [15:0] p,
                                            output int slot);
    int idx;
    idx = int'(fnv_key(a, p) % SLOTS);
    slot = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!t_active[idx]) begin
        slot = idx;
        return PR_EMPTY;
      end
      if (t_addr[idx] == a && t_port[idx] == p) begin
        slot = idx;
        return PR_MATCH;
      end
      idx = (idx + 1) % SLOTS;
    end
    return PR_FULL;
  endfunction

  // drop the least recently seen entry, lowest slot on a tie
  task automatic drop_oldest();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (t_active[i] && (best < 0 || t_seen[i] < t_seen[best])) best = i;
    if (best >= 0) begin
      t_active[best] = 1'b0;
      if (n_clients > 0) n_clients--;
      evictions++;
    end
  endtask

  function automatic int slot_of_id(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (t_active[i] && t_id[i] == id) return i;
    return -1;
  endfunction

  task automatic predict_request();
    pact_pkg::res_t r;
    probe_res_t st;
    int slot;
    r = '0;
    case (pact_pkg::op_t'(in_operation))
      pact_pkg::OP_GET_CREATE: begin
        st = probe_slot(in_peer_addr, in_peer_port, slot);
        if (st == PR_FULL) begin
          drop_oldest();
          st = probe_slot(in_peer_addr, in_peer_port, slot);
        end
        if (st == PR_FULL) begin
          r.id = bcast_id;
          r.fb = 1'b1;
        end else if (st == PR_MATCH) begin
          t_seen[slot] = in_now_seconds;
          r.id = t_id[slot];
          r.hit = 1'b1;
        end else begin
          if (n_clients >= client_limit) drop_oldest();
          t_addr[slot] = in_peer_addr;
          t_port[slot] = in_peer_port;
          t_id[slot] = issue_id;
          t_seen[slot] = in_now_seconds;
          t_proto[slot] = pact_pkg::PROTO_UNKNOWN;
          t_active[slot] = 1'b1;
          n_clients++;
          r.id = issue_id;
          issue_id = issue_id + 32'd1;
          if (issue_id < base_id) issue_id = base_id + 32'd1;
        end
      end
      pact_pkg::OP_ADDR_BY_ID: begin
        slot = slot_of_id(in_query_id);
        if (slot >= 0) begin
          r.id = in_query_id;
          r.hit = 1'b1;
          r.addr = t_addr[slot];
          r.port = t_port[slot];
        end
      end
      pact_pkg::OP_PROTO_BY_ID: begin
        slot = slot_of_id(in_query_id);
        if (slot >= 0) begin
          r.id = in_query_id;
          r.hit = 1'b1;
          r.proto = t_proto[slot];
        end
      end
      default: begin
        if (probe_slot(in_peer_addr, in_peer_port, slot) == PR_MATCH) begin
          if (t_proto[slot] == pact_pkg::PROTO_UNKNOWN &&
              (in_new_protocol == pact_pkg::PROTO_CSV ||
               in_new_protocol == pact_pkg::PROTO_BINARY))
            t_proto[slot] = in_new_protocol;
          r.id = t_id[slot];
          r.hit = 1'b1;
          r.proto = t_proto[slot];
        end
      end
    endcase
    r.count = n_clients;
    expected_results.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    pact_pkg::res_t e;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("result with no request waiting");
      fail_count++;
      return;
    end
    e = expected_results.pop_front();
    if (e.hit) hits_seen++;
    check_field("result_id", e.id, out_result_id);
    check_field("hit", 32'(e.hit), 32'(out_hit));
    check_field("fallback", 32'(e.fb), 32'(out_fallback));
    check_field("found_addr", e.addr, out_found_addr);
    check_field("found_port", 32'(e.port), 32'(out_found_port));
    check_field("protocol_out", 32'(e.proto), 32'(out_protocol_out));
    check_field("client_count", 32'(e.count), 32'(out_client_count));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      base_id = 32'h8000_0000;
      bcast_id = 32'd0;
      client_limit = 11'd1024;
      for (int i = 0; i < SLOTS; i++) begin
        t_active[i] = 1'b0;
        t_addr[i] = '0;
        t_port[i] = '0;
        t_id[i] = '0;
        t_seen[i] = '0;
        t_proto[i] = '0;
      end
      n_clients = '0;
      issue_id = 32'h8000_0001;
      expected_results.delete();
    end else begin
      // results first: a request taken on this edge cannot answer on it
      if (out_valid) check_result();
      if (start && !busy) predict_request();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pact_pkg::REG_ID_BASE: begin
            base_id = cfg_data;
            issue_id = cfg_data + 32'd1;
          end
          pact_pkg::REG_BROADCAST: bcast_id = cfg_data;
          pact_pkg::REG_MAX_CLI: client_limit = cfg_data[10:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_results.size();
  end

  initial begin
    fail_count = 0;
    outstanding = 0;
    results_seen = 0;
    hits_seen = 0;
    evictions = 0;
  end

endmodule

/* tb/peer_address_client_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_address_client_table_test
// Drives get-or-create, lookups by id and protocol updates into the client
// table under several register settings, with random gaps between requests.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module peer_address_client_table_test;

  localparam int  RANDOM_ITEMS = 560;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic        clk, rst_n, start, busy;
  logic [1:0]  in_operation, in_new_protocol;
  logic [31:0] in_peer_addr, in_query_id, in_now_seconds;
  logic [15:0] in_peer_port;
  logic        out_valid, out_hit, out_fallback;
  logic [31:0] out_result_id, out_found_addr;
  logic [15:0] out_found_port;
  logic [1:0]  out_protocol_out;
  logic [10:0] out_client_count;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count, outstanding, results_seen, hits_seen, evictions;
  longint cycles;

  // stimulus state
  logic [31:0] cur_base, clock_now;
  logic [31:0] pool_addr [16];
  logic [15:0] pool_port [16];
  bit          no_gaps;
  int          requests_sent;

  peer_address_client_table uut (.*);
  peer_address_client_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[peer_address_client_table] ERROR");
      $finish;
    end
  end

  // one request: optional gap, then hold start until the block takes it
  task automatic send_request(pact_pkg::op_t op, logic [31:0] a, logic [15:0] p,
                              logic [31:0] qid, logic [1:0] proto, logic [31:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation <= op;
    in_peer_addr <= a;
    in_peer_port <= p;
    in_query_id <= qid;
    in_new_protocol <= proto;
    in_now_seconds <= now;
    start <= 1'b1;
    // busy only moves at the rising edge, so its value here decides the next edge
    while (busy) @(negedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == pact_pkg::REG_ID_BASE) cur_base = val;
  endtask

  // random request, mostly on a small set of known keys and recent ids
  task automatic random_request();
    pact_pkg::op_t op;
    int k;
    logic [31:0] a, qid, now;
    logic [15:0] p;
    op = pact_pkg::op_t'($urandom_range(0, 3));
    k = $urandom_range(0, 15);
    if ($urandom_range(0, 4) == 0) begin
      a = $urandom();
      p = $urandom();
    end else begin
      a = pool_addr[k];
      p = pool_port[k];
    end
    if ($urandom_range(0, 5) == 0) qid = $urandom();
    else qid = cur_base + 32'd1 + $urandom_range(0, 40);
    // time mostly moves forward, sometimes ties or jumps anywhere
    case ($urandom_range(0, 7))
      0: now = $urandom();
      1: now = clock_now;
      default: begin
        clock_now = clock_now + $urandom_range(1, 3);
        now = clock_now;
      end
    endcase
    send_request(op, a, p, qid, 2'($urandom_range(0, 3)), now);
  endtask

  initial begin
    cycles = 0;
    requests_sent = 0;
    no_gaps = 0;
    start = 1'b0;
    in_operation = pact_pkg::OP_GET_CREATE;
    in_peer_addr = '0;
    in_peer_port = '0;
    in_query_id = '0;
    in_new_protocol = pact_pkg::PROTO_UNKNOWN;
    in_now_seconds = '0;
    cfg_valid = 1'b0;
    cfg_index = pact_pkg::REG_ID_BASE;
    cfg_data = '0;
    cur_base = 32'h8000_0000;
    clock_now = 32'd100;
    for (int i = 0; i < 16; i++) begin
      pool_addr[i] = $urandom();
      pool_port[i] = $urandom();
    end
    pool_addr[0] = 32'h0000_0000;
    pool_port[0] = 16'h0000;
    pool_addr[1] = 32'hFFFF_FFFF;
    pool_port[1] = 16'hFFFF;

    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes of keys, each operation, protocol rules
    send_request(pact_pkg::OP_ADDR_BY_ID, '0, '0, 32'h8000_0001,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);
    send_request(pact_pkg::OP_GET_CREATE, pool_addr[0], pool_port[0], '0,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);
    send_request(pact_pkg::OP_GET_CREATE, pool_addr[1], pool_port[1], '0,
                 pact_pkg::PROTO_UNKNOWN, 32'hFFFF_FFFF);
    send_request(pact_pkg::OP_GET_CREATE, pool_addr[0], pool_port[0], '0,
                 pact_pkg::PROTO_UNKNOWN, 32'd5);
    send_request(pact_pkg::OP_ADDR_BY_ID, '0, '0, 32'h8000_0002,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);
    send_request(pact_pkg::OP_ADDR_BY_ID, '0, '0, 32'hFFFF_FFFF,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);
    send_request(pact_pkg::OP_PROTO_BY_ID, '0, '0, 32'h8000_0001,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);
    send_request(pact_pkg::OP_SET_PROTO, pool_addr[0], pool_port[0], '0,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);
    send_request(pact_pkg::OP_SET_PROTO, pool_addr[0], pool_port[0], '0, 2'd3, 32'd0);
    send_request(pact_pkg::OP_SET_PROTO, pool_addr[0], pool_port[0], '0,
                 pact_pkg::PROTO_BINARY, 32'd0);
    send_request(pact_pkg::OP_SET_PROTO, pool_addr[0], pool_port[0], '0,
                 pact_pkg::PROTO_CSV, 32'd0);
    send_request(pact_pkg::OP_SET_PROTO, pool_addr[1], pool_port[1], '0,
                 pact_pkg::PROTO_CSV, 32'd0);
    send_request(pact_pkg::OP_SET_PROTO, pool_addr[2], pool_port[2], '0,
                 pact_pkg::PROTO_CSV, 32'd0);
    send_request(pact_pkg::OP_PROTO_BY_ID, '0, '0, 32'h8000_0001,
                 pact_pkg::PROTO_UNKNOWN, 32'd0);

    // id wrap near the top of the range, zero limit evicts on every create
    write_reg(pact_pkg::REG_ID_BASE, 32'hFFFF_FFFE);
    write_reg(pact_pkg::REG_BROADCAST, 32'hFFFF_FFFF);
    write_reg(pact_pkg::REG_MAX_CLI, 32'd0);
    for (int i = 2; i < 6; i++)
      send_request(pact_pkg::OP_GET_CREATE, pool_addr[i], pool_port[i], '0,
                   pact_pkg::PROTO_UNKNOWN, 32'd10 + i);
    // lowered limit: grow to six, then drop to one
    write_reg(pact_pkg::REG_MAX_CLI, 32'd6);
    for (int i = 6; i < 12; i++)
      send_request(pact_pkg::OP_GET_CREATE, pool_addr[i], pool_port[i], '0,
                   pact_pkg::PROTO_UNKNOWN, 32'd20 + i);
    write_reg(pact_pkg::REG_MAX_CLI, 32'd1);
    send_request(pact_pkg::OP_GET_CREATE, pool_addr[12], pool_port[12], '0,
                 pact_pkg::PROTO_UNKNOWN, 32'd40);
    send_request(pact_pkg::OP_GET_CREATE, pool_addr[13], pool_port[13], '0,
                 pact_pkg::PROTO_UNKNOWN, 32'd40);

    // random phases under different settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(pact_pkg::REG_ID_BASE, 32'd0);
          write_reg(pact_pkg::REG_BROADCAST, 32'd0);
          write_reg(pact_pkg::REG_MAX_CLI, 32'd8);
        end
        1: begin
          write_reg(pact_pkg::REG_ID_BASE, $urandom());
          write_reg(pact_pkg::REG_MAX_CLI, 32'd1024);
        end
        2: begin
          write_reg(pact_pkg::REG_BROADCAST, $urandom());
          write_reg(pact_pkg::REG_MAX_CLI, 32'd3);
        end
        default: begin
          write_reg(pact_pkg::REG_ID_BASE, 32'hFFFF_FFFF);
          write_reg(pact_pkg::REG_MAX_CLI, $urandom_range(1, 20));
        end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        // stretches with no gaps, and a full stop until results are in
        if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (i == 70) drain();
        random_request();
      end
      no_gaps = 0;
    end

    drain();
    repeat (50) @(negedge clk);
    $display("Covered %0d requests, %0d results, %0d hits, %0d evictions.",
             requests_sent, results_seen, hits_seen, evictions);
    if (fail_count == 0) begin
      $display("[peer_address_client_table] OK");
    end else begin
      $display("[peer_address_client_table] ERROR");
    end
    $finish;
  end

endmodule
